// ===== design/vdes_pkg.sv =====
// Package for the vehicle drive enable sequencer.
// Phase codes, LED codes, register map and the word/state structs.
// No dependencies; imported by every module of the block.
package vdes_pkg;

    // Sequencer phase codes
    localparam logic [2:0] PH_STARTUP    = 3'd0;
    localparam logic [2:0] PH_NOT_ACTIVE = 3'd1;
    localparam logic [2:0] PH_ACTIVE     = 3'd2;
    localparam logic [2:0] PH_ENABLING   = 3'd3;
    localparam logic [2:0] PH_SOUND      = 3'd4;
    localparam logic [2:0] PH_DRIVE      = 3'd5;

    // LED colors
    localparam logic [2:0] LED_GREEN  = 3'd0;
    localparam logic [2:0] LED_RED    = 3'd1;
    localparam logic [2:0] LED_YELLOW = 3'd2;
    localparam logic [2:0] LED_ORANGE = 3'd3;
    localparam logic [2:0] LED_PINK   = 3'd4;

    // LED blink patterns
    localparam logic [1:0] PAT_CODE3 = 2'd0;
    localparam logic [1:0] PAT_CODE0 = 2'd1;
    localparam logic [1:0] PAT_CODE5 = 2'd2;
    localparam logic [1:0] PAT_ALT21 = 2'd3;

    // Register map
    localparam int         ADDR_W          = 3;
    localparam logic [0:0] REG_SOUND_TICKS = 1'b0;
    localparam logic [15:0] SOUND_TICKS_RST = 16'd200;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

    // One input word (one control-loop tick)
    typedef struct packed {
        logic [14:0] torque_request;
        logic        pedals_agree;
        logic        brake_ok;
        logic        accel_ok;
        logic        inverter_is_off;
        logic        inverter_is_ready;
        logic        enable_timed_out;
        logic        brake_held;
        logic        start_button;
        logic        hv_active;
    } t_in;

    // Sequencer state carried from tick to tick
    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] sound_count;
        logic        buzzer;
        logic [2:0]  flags;
    } t_state;

    // One result word
    typedef struct packed {
        logic [2:0]  plausible_flags;
        logic [14:0] torque_command;
        logic        torque_valid;
        logic        kick_value;
        logic        kick_valid;
        logic        precharge_request;
        logic        start_inverter_pulse;
        logic        clear_fault_pulse;
        logic        buzzer_on;
        logic [1:0]  led_pattern;
        logic [2:0]  led_color;
        logic [2:0]  phase;
    } t_out;

endpackage

// ===== design/vdes_apb_regs.sv =====
// APB configuration register for the drive enable sequencer (sound_ticks).
// Depends on vdes_pkg for the register map and reset value.
module vdes_apb_regs import vdes_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [15:0]       o_sound_ticks
);

    logic [15:0] r_sound_ticks;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_SOUND_TICKS);

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound_ticks <= SOUND_TICKS_RST;
        end else if (wr_en) begin
            r_sound_ticks <= pwdata[15:0];
        end
    end

    // read back
    always_comb begin
        if (paddr[2] == REG_SOUND_TICKS) begin
            prdata = {16'b0, r_sound_ticks};
        end else begin
            prdata = 32'b0;
        end
    end

    assign o_sound_ticks = r_sound_ticks;

endmodule

// ===== design/vdes_step.sv =====
// Next-state and result logic for one tick of the drive enable sequencer.
// Purely combinational; depends on vdes_pkg for codes and structs.
module vdes_step import vdes_pkg::*; (
    input  t_state      i_state,
    input  t_in         i_word,
    input  logic [15:0] i_sound_ticks,
    output t_state      o_state,
    output t_out        o_word
);

    logic [2:0]  target;
    logic [15:0] cnt_inc;
    logic [15:0] cnt_upd;
    logic [2:0]  flags_upd;
    logic        clr, start, pre, kv, kval, tv;
    logic [14:0] tq;
    logic [2:0]  color;
    logic [1:0]  pattern;

    assign cnt_inc = (i_state.sound_count == COUNT_MAX) ? i_state.sound_count
                                                        : i_state.sound_count + 16'd1;

    // per-phase behavior, picks the target phase
    always_comb begin
        target    = i_state.phase;
        cnt_upd   = i_state.sound_count;
        flags_upd = i_state.flags;
        pre       = 1'b0;
        kv        = 1'b0;
        kval      = 1'b0;
        tv        = 1'b0;
        tq        = 15'd0;
        unique case (i_state.phase)
            PH_NOT_ACTIVE: begin
                pre = 1'b1;
                if (i_word.hv_active) target = PH_ACTIVE;
            end
            PH_ACTIVE: begin
                if (!i_word.hv_active) begin
                    target = PH_NOT_ACTIVE;
                end else begin
                    kv = 1'b1;
                    if (i_word.start_button && i_word.brake_held) target = PH_ENABLING;
                end
            end
            PH_ENABLING: begin
                priority if (!i_word.hv_active)       target = PH_NOT_ACTIVE;
                else if (i_word.enable_timed_out)     target = PH_ACTIVE;
                else if (i_word.inverter_is_ready)    target = PH_SOUND;
                else                                  target = i_state.phase;
            end
            PH_SOUND: begin
                priority if (!i_word.hv_active) begin
                    target = PH_NOT_ACTIVE;
                end else if (!i_word.inverter_is_off) begin
                    target = PH_ACTIVE;
                end else begin
                    kv      = 1'b1;
                    kval    = 1'b1;
                    cnt_upd = cnt_inc;
                    if (cnt_inc >= i_sound_ticks) target = PH_DRIVE;
                end
            end
            PH_DRIVE: begin
                priority if (!i_word.hv_active) begin
                    target = PH_NOT_ACTIVE;
                end else if (!i_word.inverter_is_off) begin
                    target = PH_ACTIVE;
                end else begin
                    flags_upd = {i_word.pedals_agree, i_word.brake_ok, i_word.accel_ok};
                    tv        = 1'b1;
                    if (i_word.accel_ok && i_word.brake_ok && i_word.pedals_agree)
                        tq = i_word.torque_request;
                end
            end
            default: begin
                // startup and unused codes hold
            end
        endcase
    end

    // exit and entry actions on a phase change
    always_comb begin
        o_state.phase       = i_state.phase;
        o_state.sound_count = cnt_upd;
        o_state.buzzer      = i_state.buzzer;
        o_state.flags       = flags_upd;
        clr                 = 1'b0;
        start               = 1'b0;
        if (target != i_state.phase) begin
            if (i_state.phase == PH_NOT_ACTIVE) clr = 1'b1;
            if (i_state.phase == PH_SOUND) o_state.buzzer = 1'b0;
            o_state.phase = target;
            if (target == PH_ENABLING) begin
                clr   = 1'b1;
                start = 1'b1;
            end
            if (target == PH_SOUND) begin
                o_state.buzzer      = 1'b1;
                o_state.sound_count = 16'd0;
            end
        end
    end

    // LED from the phase after the tick
    always_comb begin
        unique case (o_state.phase)
            PH_ACTIVE:   begin color = LED_RED;    pattern = PAT_CODE0; end
            PH_ENABLING: begin color = LED_YELLOW; pattern = PAT_CODE5; end
            PH_SOUND:    begin color = LED_ORANGE; pattern = PAT_ALT21; end
            PH_DRIVE:    begin color = LED_PINK;   pattern = PAT_CODE3; end
            default:     begin color = LED_GREEN;  pattern = PAT_CODE3; end
        endcase
    end

    assign o_word.phase                = o_state.phase;
    assign o_word.led_color            = color;
    assign o_word.led_pattern          = pattern;
    assign o_word.buzzer_on            = o_state.buzzer;
    assign o_word.clear_fault_pulse    = clr;
    assign o_word.start_inverter_pulse = start;
    assign o_word.precharge_request    = pre;
    assign o_word.kick_valid           = kv;
    assign o_word.kick_value           = kval;
    assign o_word.torque_valid         = tv;
    assign o_word.torque_command       = tq;
    assign o_word.plausible_flags      = o_state.flags;

endmodule

// ===== design/vehicle_drive_enable_sequencer_unit.sv =====
// A word goes into the input register; its result is held in the result register,
// which also holds the new sequencer state.
// Throughput: one word per cycle while the output is not stalled.
// Output stalls back up through the input register to s_axis_tready.
// Reset (synchronous, active low): phase not active, counters and flags zero,
// sound_ticks 200, both stages empty.
module vehicle_drive_enable_sequencer_unit import vdes_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata from bit 0: hv_active, start_button, brake_held, enable_timed_out,
    // inverter_is_ready, inverter_is_off, accel_ok, brake_ok, pedals_agree,
    // torque_request[14:0]
    input  logic [23:0]       s_axis_tdata,
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // tdata from bit 0: phase[2:0], led_color[2:0], led_pattern[1:0], buzzer_on,
    // clear_fault_pulse, start_inverter_pulse, precharge_request, kick_valid,
    // kick_value, torque_valid, torque_command[14:0], plausible_flags[2:0], zero pad
    output logic [39:0]       m_axis_tdata,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0] sound_ticks;
    logic        r_in_valid;
    t_in         r_in;
    logic        r_out_valid;
    t_out        r_out;
    t_state      r_state;
    t_state      n_state;
    t_out        n_out;
    logic        adv;
    logic        in_acc;

    vdes_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_sound_ticks (sound_ticks)
    );

    vdes_step u_step (
        .i_state       (r_state),
        .i_word        (r_in),
        .i_sound_ticks (sound_ticks),
        .o_state       (n_state),
        .o_word        (n_out)
    );

    // handshakes
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= t_in'(s_axis_tdata);
        end
    end

    // sequencer state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid         <= 1'b0;
            r_state.phase       <= PH_NOT_ACTIVE;
            r_state.sound_count <= 16'd0;
            r_state.buzzer      <= 1'b0;
            r_state.flags       <= 3'd0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
            r_state     <= n_state;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out};

endmodule
